// ===== rtl/core/bgw_pkg.sv =====
// ----------------------------------------------------------------------------
// bgw_pkg: shared types and constants of the bilinear grid warp
// Field widths, lattice geometry, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgw_pkg;

	localparam int COORD_W   = 32;
	localparam int IDX_W     = 9;
	localparam int CELL_W    = 5;
	localparam int CIDX_W    = 4;
	localparam int MAX_CELLS = 16;
	localparam int LAT_SIDE  = MAX_CELLS + 1;
	localparam int LAT_DEPTH = LAT_SIDE * LAT_SIDE;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 64;
	localparam int G_W       = PROD_W - FRAC_BITS;
	localparam int SCALE_W   = 31;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd5;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_XFORM = 1'b1;

	typedef struct packed {
		logic                      xform;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W:0]   a;
		logic signed [COORD_W:0]   b;
	} bgw_entry_t;

endpackage

// ===== rtl/core/bgw_smul.sv =====
// ----------------------------------------------------------------------------
// bgw_smul: pipelined saturating signed multiplier
// Three stages: magnitudes, two partial products, sum with clamp to +-2^62.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgw_smul
	import bgw_pkg::*;
#(
	parameter int AW = 33,
	parameter int BW = 48
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [PROD_W-1:0] p,
	output logic                     ovf
);

	localparam int HW = (BW + 1) / 2;
	localparam int UW = BW - HW;
	localparam int FW = AW + BW;
	localparam logic [FW-1:0] LIM = FW'(64'h4000_0000_0000_0000);

	logic [AW-1:0]    ma_s1;
	logic [BW-1:0]    mb_s1;
	logic             neg_s1;
	logic [AW+HW-1:0] plo_s2;
	logic [AW+UW-1:0] phi_s2;
	logic             neg_s2;
	logic [FW-1:0]    full;
	logic             sat;
	logic [62:0]      mag;

	assign full = FW'(plo_s2) + (FW'(phi_s2) << HW);
	assign sat  = full > LIM;
	assign mag  = sat ? LIM[62:0] : full[62:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= a[AW-1] ? AW'(-a) : AW'(a);
			mb_s1  <= b[BW-1] ? BW'(-b) : BW'(b);
			neg_s1 <= a[AW-1] ^ b[BW-1];
			plo_s2 <= ma_s1 * mb_s1[HW-1:0];
			phi_s2 <= ma_s1 * mb_s1[BW-1:HW];
			neg_s2 <= neg_s1;
			p      <= neg_s2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			ovf    <= sat;
		end
	end

endmodule

// ===== rtl/core/bgw_front.sv =====
// ----------------------------------------------------------------------------
// bgw_front: input classification and item queue
// Drops loads beyond the lattice, offsets transform points by the origin and
// queues the result for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgw_front
	import bgw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic                      s_tuser,   // req_type
	input  logic [79:0]               s_tdata,   // point_index, coord_x, coord_y
	input  logic signed [COORD_W-1:0] origin_x,
	input  logic signed [COORD_W-1:0] origin_y,
	input  logic                      pop,
	output logic                      q_empty,
	output bgw_entry_t                q_head
);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	bgw_entry_t        q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              full, push, do_pop;
	logic [IDX_W-1:0]  idx;
	logic signed [COORD_W:0] cx, cy;
	bgw_entry_t        ent;

	assign idx  = s_tdata[IDX_W-1:0];
	assign cx   = {s_tdata[IDX_W+COORD_W-1], s_tdata[IDX_W+COORD_W-1:IDX_W]};
	assign cy   = {s_tdata[IDX_W+2*COORD_W-1], s_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W]};
	assign full = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign s_tready = !full;
	assign q_empty  = cnt_q == '0;
	assign do_pop   = pop && !q_empty;

	// Loads outside the store are accepted and discarded here.
	assign push = s_tvalid && s_tready
		&& (s_tuser == REQ_XFORM || idx < IDX_W'(LAT_DEPTH));

	always_comb begin
		ent.xform = s_tuser;
		ent.idx   = idx;
		if (s_tuser == REQ_XFORM) begin
			ent.a = cx - {origin_x[COORD_W-1], origin_x};
			ent.b = cy - {origin_y[COORD_W-1], origin_y};
		end else begin
			ent.a = cx;
			ent.b = cy;
		end
	end

	assign q_head = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
		end
	end

endmodule

// ===== rtl/core/bgw_back.sv =====
// ----------------------------------------------------------------------------
// bgw_back: warp pipeline
// Grid mapping, cell pick, lattice reads and two rounds of bilinear blending.
// The whole pipeline advances together and holds while the result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgw_back
	import bgw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  bgw_entry_t                q_head,
	input  logic                      q_empty,
	output logic                      pop,
	input  logic [SCALE_W-1:0]        scale_x,
	input  logic [SCALE_W-1:0]        scale_y,
	input  logic [CELL_W-1:0]         cols,
	input  logic [CELL_W-1:0]         rows,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic signed [COORD_W-1:0] warped_x,
	output logic signed [COORD_W-1:0] warped_y,
	output logic                      overflow
);

	localparam int NST = 13;

	logic en;
	logic [NST:1] xv_q;
	logic [5:1]   lv_q;

	assign en  = !m_tvalid || m_tready;
	assign pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xv_q     <= '0;
			lv_q     <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			xv_q     <= {xv_q[NST-1:1], !q_empty && q_head.xform};
			lv_q     <= {lv_q[4:1], !q_empty && !q_head.xform};
			m_tvalid <= xv_q[NST];
		end
	end

	// Load side band, stages one to five.
	logic [IDX_W-1:0]   ld_idx_s1, ld_idx_s2, ld_idx_s3, ld_idx_s4, ld_idx_s5;
	logic [2*COORD_W-1:0] ld_pt_s1, ld_pt_s2, ld_pt_s3, ld_pt_s4, ld_pt_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ld_idx_s1 <= q_head.idx;
			ld_pt_s1  <= {q_head.b[COORD_W-1:0], q_head.a[COORD_W-1:0]};
			ld_idx_s2 <= ld_idx_s1;  ld_pt_s2 <= ld_pt_s1;
			ld_idx_s3 <= ld_idx_s2;  ld_pt_s3 <= ld_pt_s2;
			ld_idx_s4 <= ld_idx_s3;  ld_pt_s4 <= ld_pt_s3;
			ld_idx_s5 <= ld_idx_s4;  ld_pt_s5 <= ld_pt_s4;
		end
	end

	// Stages one to three: offset point times reciprocal scale.
	logic signed [PROD_W-1:0] gpx_s3, gpy_s3;
	logic                     gox_s3, goy_s3;

	bgw_smul #(.AW(COORD_W+1), .BW(SCALE_W+1)) u_gmul_x (
		.clk(clk), .en(en), .a(q_head.a), .b($signed({1'b0, scale_x})),
		.p(gpx_s3), .ovf(gox_s3)
	);
	bgw_smul #(.AW(COORD_W+1), .BW(SCALE_W+1)) u_gmul_y (
		.clk(clk), .en(en), .a(q_head.b), .b($signed({1'b0, scale_y})),
		.p(gpy_s3), .ovf(goy_s3)
	);

	// Stage four: cell pick and fraction.
	logic signed [G_W-1:0] gx, gy, u_s4, v_s4;
	logic [CIDX_W-1:0]     cx, cy, cx_s4, cy_s4;
	logic                  ov_s4;
	logic [CIDX_W-1:0]     cmax, rmax;

	assign gx   = gpx_s3[PROD_W-1:FRAC_BITS];
	assign gy   = gpy_s3[PROD_W-1:FRAC_BITS];
	assign cmax = CIDX_W'(cols - 1'b1);
	assign rmax = CIDX_W'(rows - 1'b1);

	always_comb begin
		if (gx[G_W-1]) begin
			cx = '0;
		end else if (gx[G_W-1:FRAC_BITS] > (G_W-FRAC_BITS)'(cmax)) begin
			cx = cmax;
		end else begin
			cx = gx[FRAC_BITS+CIDX_W-1:FRAC_BITS];
		end
		if (gy[G_W-1]) begin
			cy = '0;
		end else if (gy[G_W-1:FRAC_BITS] > (G_W-FRAC_BITS)'(rmax)) begin
			cy = rmax;
		end else begin
			cy = gy[FRAC_BITS+CIDX_W-1:FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s4 <= cx;
			cy_s4 <= cy;
			u_s4  <= gx - $signed({(G_W-FRAC_BITS-CIDX_W)'(0), cx, FRAC_BITS'(0)});
			v_s4  <= gy - $signed({(G_W-FRAC_BITS-CIDX_W)'(0), cy, FRAC_BITS'(0)});
			ov_s4 <= gox_s3 | goy_s3;
		end
	end

	// Stage five: corner addresses.
	logic [IDX_W-1:0]      a00, a10, a00_s5, a01_s5, a10_s5, a11_s5;
	logic signed [G_W-1:0] u_s5, v_s5;
	logic                  ov_s5;

	assign a00 = IDX_W'(cy_s4) * IDX_W'(cols + 1'b1) + IDX_W'(cx_s4);
	assign a10 = a00 + IDX_W'(cols) + 1'b1;

	always_ff @(posedge clk) begin
		if (en) begin
			a00_s5 <= a00;
			a01_s5 <= a00 + 1'b1;
			a10_s5 <= a10;
			a11_s5 <= a10 + 1'b1;
			u_s5   <= u_s4;
			v_s5   <= v_s4;
			ov_s5  <= ov_s4;
		end
	end

	// Stage six: two copies of the lattice, each with two read ports.
	logic [2*COORD_W-1:0] mem_top [LAT_DEPTH];
	logic [2*COORD_W-1:0] mem_bot [LAT_DEPTH];
	logic [2*COORD_W-1:0] r00_s6, r01_s6, r10_s6, r11_s6;
	logic signed [G_W-1:0] u_s6, v_s6;
	logic                  ov_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			if (lv_q[5]) begin
				mem_top[ld_idx_s5] <= ld_pt_s5;
				mem_bot[ld_idx_s5] <= ld_pt_s5;
			end
			r00_s6 <= mem_top[a00_s5];
			r01_s6 <= mem_top[a01_s5];
			r10_s6 <= mem_bot[a10_s5];
			r11_s6 <= mem_bot[a11_s5];
			u_s6   <= u_s5;
			v_s6   <= v_s5;
			ov_s6  <= ov_s5;
		end
	end

	// Stages seven to nine: blend along the cell's x fraction.
	logic signed [COORD_W:0] dxt, dxb, dyt, dyb;
	logic signed [PROD_W-1:0] pxt_s9, pxb_s9, pyt_s9, pyb_s9;
	logic oxt_s9, oxb_s9, oyt_s9, oyb_s9;

	assign dxt = $signed({r01_s6[COORD_W-1], r01_s6[COORD_W-1:0]})
		- $signed({r00_s6[COORD_W-1], r00_s6[COORD_W-1:0]});
	assign dxb = $signed({r11_s6[COORD_W-1], r11_s6[COORD_W-1:0]})
		- $signed({r10_s6[COORD_W-1], r10_s6[COORD_W-1:0]});
	assign dyt = $signed({r01_s6[2*COORD_W-1], r01_s6[2*COORD_W-1:COORD_W]})
		- $signed({r00_s6[2*COORD_W-1], r00_s6[2*COORD_W-1:COORD_W]});
	assign dyb = $signed({r11_s6[2*COORD_W-1], r11_s6[2*COORD_W-1:COORD_W]})
		- $signed({r10_s6[2*COORD_W-1], r10_s6[2*COORD_W-1:COORD_W]});

	bgw_smul #(.AW(COORD_W+1), .BW(G_W)) u_l1_xt (
		.clk(clk), .en(en), .a(dxt), .b(u_s6), .p(pxt_s9), .ovf(oxt_s9));
	bgw_smul #(.AW(COORD_W+1), .BW(G_W)) u_l1_xb (
		.clk(clk), .en(en), .a(dxb), .b(u_s6), .p(pxb_s9), .ovf(oxb_s9));
	bgw_smul #(.AW(COORD_W+1), .BW(G_W)) u_l1_yt (
		.clk(clk), .en(en), .a(dyt), .b(u_s6), .p(pyt_s9), .ovf(oyt_s9));
	bgw_smul #(.AW(COORD_W+1), .BW(G_W)) u_l1_yb (
		.clk(clk), .en(en), .a(dyb), .b(u_s6), .p(pyb_s9), .ovf(oyb_s9));

	logic [4*COORD_W-1:0]  base_s7, base_s8, base_s9;
	logic signed [G_W-1:0] v_s7, v_s8, v_s9;
	logic                  ov_s7, ov_s8, ov_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			base_s7 <= {r10_s6[2*COORD_W-1:COORD_W], r00_s6[2*COORD_W-1:COORD_W],
				r10_s6[COORD_W-1:0], r00_s6[COORD_W-1:0]};
			base_s8 <= base_s7;
			base_s9 <= base_s8;
			v_s7 <= v_s6;  v_s8 <= v_s7;  v_s9 <= v_s8;
			ov_s7 <= ov_s6;  ov_s8 <= ov_s7;  ov_s9 <= ov_s8;
		end
	end

	// Stage ten: top and bottom edge values.
	logic signed [G_W-1:0] tx_s10, bx_s10, ty_s10, by_s10, v_s10;
	logic                  ov_s10;

	function automatic logic signed [G_W-1:0] add_base(
		input logic [COORD_W-1:0] base, input logic signed [PROD_W-1:0] prod);
		logic signed [G_W-1:0] b;
		b = $signed({{(G_W-COORD_W){base[COORD_W-1]}}, base});
		return b + prod[PROD_W-1:FRAC_BITS];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s10 <= add_base(base_s9[COORD_W-1:0], pxt_s9);
			bx_s10 <= add_base(base_s9[2*COORD_W-1:COORD_W], pxb_s9);
			ty_s10 <= add_base(base_s9[3*COORD_W-1:2*COORD_W], pyt_s9);
			by_s10 <= add_base(base_s9[4*COORD_W-1:3*COORD_W], pyb_s9);
			v_s10  <= v_s9;
			ov_s10 <= ov_s9 | oxt_s9 | oxb_s9 | oyt_s9 | oyb_s9;
		end
	end

	// Stages eleven to thirteen: blend along the y fraction.
	logic signed [G_W:0]      ex, ey;
	logic signed [PROD_W-1:0] qx_s13, qy_s13;
	logic                     oqx_s13, oqy_s13;

	assign ex = {bx_s10[G_W-1], bx_s10} - {tx_s10[G_W-1], tx_s10};
	assign ey = {by_s10[G_W-1], by_s10} - {ty_s10[G_W-1], ty_s10};

	bgw_smul #(.AW(G_W+1), .BW(G_W)) u_l2_x (
		.clk(clk), .en(en), .a(ex), .b(v_s10), .p(qx_s13), .ovf(oqx_s13));
	bgw_smul #(.AW(G_W+1), .BW(G_W)) u_l2_y (
		.clk(clk), .en(en), .a(ey), .b(v_s10), .p(qy_s13), .ovf(oqy_s13));

	logic signed [G_W-1:0] tx_s11, tx_s12, tx_s13, ty_s11, ty_s12, ty_s13;
	logic                  ov_s11, ov_s12, ov_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s11 <= tx_s10;  tx_s12 <= tx_s11;  tx_s13 <= tx_s12;
			ty_s11 <= ty_s10;  ty_s12 <= ty_s11;  ty_s13 <= ty_s12;
			ov_s11 <= ov_s10;  ov_s12 <= ov_s11;  ov_s13 <= ov_s12;
		end
	end

	// Final sum and saturation into the output register.
	logic signed [G_W:0]     fx, fy;
	logic signed [G_W:0]     hi_lim, lo_lim;
	logic                    shx, slx, shy, sly;

	assign fx = {tx_s13[G_W-1], tx_s13}
		+ {qx_s13[PROD_W-1], qx_s13[PROD_W-1:FRAC_BITS]};
	assign fy = {ty_s13[G_W-1], ty_s13}
		+ {qy_s13[PROD_W-1], qy_s13[PROD_W-1:FRAC_BITS]};
	assign hi_lim = (G_W+1)'((65'sd1 <<< (COORD_W-1)) - 1);
	assign lo_lim = ~hi_lim;
	assign shx = fx > hi_lim;
	assign slx = fx < lo_lim;
	assign shy = fy > hi_lim;
	assign sly = fy < lo_lim;

	always_ff @(posedge clk) begin
		if (en) begin
			warped_x <= shx ? hi_lim[COORD_W-1:0] : slx ? lo_lim[COORD_W-1:0]
				: fx[COORD_W-1:0];
			warped_y <= shy ? hi_lim[COORD_W-1:0] : sly ? lo_lim[COORD_W-1:0]
				: fy[COORD_W-1:0];
			overflow <= ov_s13 | oqx_s13 | oqy_s13 | shx | slx | shy | sly;
		end
	end

endmodule

// ===== rtl/core/bilinear_grid_warp.sv =====
// ----------------------------------------------------------------------------
// bilinear_grid_warp: point warp through a lattice of control points
//
// Channel  Dir  Handshake            Contents
// s_*      in   s_tvalid/s_tready    tuser req_type, tdata index and point
// m_*      out  m_tvalid/m_tready    tdata warped point and overflow
// cfg_*    in   cfg_valid/cfg_ready  register index and write data
//
// One item enters per cycle while the queue has room; a transform result passes
// through the queue, thirteen pipeline stages (three chained multiplier
// pipelines, cell pick, addressing and lattice read) and the output register.
// Loads produce no result. Reset clears control state and the registers; the
// lattice is not cleared. A stalled result holds the whole back pipeline,
// while the four-entry queue keeps accepting input until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_grid_warp
	import bgw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 s_tuser,   // req_type
	input  logic [79:0]          s_tdata,   // point_index, coord_x, coord_y, zero pad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [71:0]          m_tdata,   // warped_x, warped_y, overflow, zero pad
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [SCALE_W-1:0]        scale_x_q, scale_y_q;
	logic [CELL_W-1:0]         cols_q, rows_q, cols, rows;
	logic                      pop, q_empty, overflow;
	bgw_entry_t                q_head;
	logic signed [COORD_W-1:0] warped_x, warped_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			scale_x_q  <= SCALE_W'(65536);
			scale_y_q  <= SCALE_W'(65536);
			cols_q     <= CELL_W'(1);
			rows_q     <= CELL_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= cfg_data;
				CFG_ORIGIN_Y: origin_y_q <= cfg_data;
				CFG_SCALE_X:  scale_x_q  <= cfg_data[SCALE_W-1:0];
				CFG_SCALE_Y:  scale_y_q  <= cfg_data[SCALE_W-1:0];
				CFG_COLUMNS:  cols_q     <= cfg_data[CELL_W-1:0];
				CFG_ROWS:     rows_q     <= cfg_data[CELL_W-1:0];
				default: ;
			endcase
		end
	end

	// Cell counts outside one to sixteen are pulled back into range.
	assign cols = (cols_q == '0) ? CELL_W'(1)
		: (cols_q > CELL_W'(MAX_CELLS)) ? CELL_W'(MAX_CELLS) : cols_q;
	assign rows = (rows_q == '0) ? CELL_W'(1)
		: (rows_q > CELL_W'(MAX_CELLS)) ? CELL_W'(MAX_CELLS) : rows_q;

	bgw_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.origin_x(origin_x_q), .origin_y(origin_y_q),
		.pop(pop), .q_empty(q_empty), .q_head(q_head)
	);

	bgw_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_head(q_head), .q_empty(q_empty), .pop(pop),
		.scale_x(scale_x_q), .scale_y(scale_y_q), .cols(cols), .rows(rows),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.warped_x(warped_x), .warped_y(warped_y), .overflow(overflow)
	);

	assign m_tdata = {7'd0, overflow, warped_y, warped_x};

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bilinear_grid_warp
// Preloads the whole lattice and walks a short table of directed items. It
// then runs random loads and warps under several grid settings. Every result
// is checked against a typed row's value or the bench's fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
	import bgw_pkg::*;
;

	localparam longint PROD_LIM = longint'(1) << 62;
	localparam int     DRAIN_CYCLES = 40;
	localparam int     ITEMS_PER_PHASE = 250;
	localparam int     NUM_PHASES = 5;

	typedef struct {
		logic [COORD_W-1:0] wx;
		logic [COORD_W-1:0] wy;
		logic               ov;
	} warp_res_t;

	typedef struct {
		logic        req;
		int unsigned idx;
		logic [31:0] x;
		logic [31:0] y;
		bit          typed;
		logic [31:0] ex;
		logic [31:0] ey;
		logic        eov;
	} table_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic                 s_tuser;   // req_type
	logic [79:0]          s_tdata;   // point_index, coord_x, coord_y, zero pad
	logic                 m_tvalid;
	logic                 m_tready;
	logic [71:0]          m_tdata;   // warped_x, warped_y, overflow, zero pad
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	bilinear_grid_warp dut (.*);

	// Predictor copy of the registers and the lattice.
	longint      org_x, org_y, scl_x, scl_y;
	logic [4:0]  n_cols, n_rows;
	longint      lat_x [LAT_DEPTH];
	longint      lat_y [LAT_DEPTH];
	bit          ov_acc;

	warp_res_t   pending_warps [$];
	int          errors;
	int          n_items, n_results, n_ovf, n_ignored;
	bit          stall_req;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	task automatic report(string what, longint got, longint want);
		$display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, n_results);
		errors++;
	endtask

	function automatic longint mul_sat(longint a, longint b);
		longint unsigned ma, mb;
		bit              neg;
		ma  = a < 0 ? longint'(-a) : a;
		mb  = b < 0 ? longint'(-b) : b;
		neg = (a < 0) != (b < 0);
		if (ma != 0 && mb > longint'(PROD_LIM) / ma) begin
			ov_acc = 1'b1;
			return neg ? -PROD_LIM : PROD_LIM;
		end
		return neg ? -longint'(ma * mb) : longint'(ma * mb);
	endfunction

	function automatic longint lerp16(longint p, longint q, longint t);
		return p + (mul_sat(q - p, t) >>> 16);
	endfunction

	function automatic int unsigned cells(logic [4:0] n);
		if (n < 1) return 1;
		if (n > MAX_CELLS) return MAX_CELLS;
		return n;
	endfunction

	function automatic logic [COORD_W-1:0] clip_coord(longint v);
		if (v > 64'sh7FFFFFFF) begin
			ov_acc = 1'b1;
			return 32'h7FFFFFFF;
		end
		if (v < -64'sh80000000) begin
			ov_acc = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic warp_res_t warp_point(logic [31:0] px, logic [31:0] py);
		int unsigned c, r, i00, i10;
		longint      gx, gy, kx, ky, u, v, tx, bx, ty, by;
		warp_res_t   res;
		c      = cells(n_cols);
		r      = cells(n_rows);
		ov_acc = 1'b0;
		gx = mul_sat(longint'(signed'(px)) - org_x, scl_x) >>> 16;
		gy = mul_sat(longint'(signed'(py)) - org_y, scl_y) >>> 16;
		kx = gx >>> 16;
		ky = gy >>> 16;
		if (kx < 0) kx = 0;
		if (kx > c - 1) kx = c - 1;
		if (ky < 0) ky = 0;
		if (ky > r - 1) ky = r - 1;
		u   = gx - kx * 65536;
		v   = gy - ky * 65536;
		i00 = ky * (c + 1) + kx;
		i10 = i00 + c + 1;
		tx = lerp16(lat_x[i00], lat_x[i00 + 1], u);
		bx = lerp16(lat_x[i10], lat_x[i10 + 1], u);
		ty = lerp16(lat_y[i00], lat_y[i00 + 1], u);
		by = lerp16(lat_y[i10], lat_y[i10 + 1], u);
		res.wx = clip_coord(lerp16(tx, bx, v));
		res.wy = clip_coord(lerp16(ty, by, v));
		res.ov = ov_acc;
		return res;
	endfunction

	// Drives one item and waits for its transaction; the expectation is queued
	// at the accepting edge.
	task automatic send_item(logic req, int unsigned idx, logic [31:0] x, logic [31:0] y,
			bit typed, warp_res_t want);
		warp_res_t exp_res;
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {7'd0, y, x, idx[8:0]};
		do @(posedge clk); while (!s_tready);
		n_items++;
		if (req == REQ_LOAD) begin
			if (idx[8:0] < LAT_DEPTH) begin
				lat_x[idx[8:0]] = longint'(signed'(x));
				lat_y[idx[8:0]] = longint'(signed'(y));
			end else begin
				n_ignored++;
			end
		end else begin
			exp_res = typed ? want : warp_point(x, y);
			pending_warps = {pending_warps, exp_res};
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic input_gap(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ORIGIN_X: org_x = longint'(signed'(val));
			CFG_ORIGIN_Y: org_y = longint'(signed'(val));
			CFG_SCALE_X:  scl_x = val[30:0];
			CFG_SCALE_Y:  scl_y = val[30:0];
			CFG_COLUMNS:  n_cols = val[4:0];
			CFG_ROWS:     n_rows = val[4:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_warps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A coordinate that mostly lands inside the grid along one axis, with some
	// margin on either side so extrapolation is exercised.
	function automatic logic [31:0] grid_coord(longint org, longint scl, logic [4:0] n);
		longint span, off;
		span = (scl == 0) ? 64'sh7FFFFFFF : (longint'(cells(n)) << 32) / scl;
		if (span > 64'sh7FFFFFFF) span = 64'sh7FFFFFFF;
		if (span < 8) span = 8;
		off = longint'($urandom_range(0, 32'(span + span / 4))) - span / 8;
		return 32'(org + off);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_warps.size() == 0) begin
				report("unexpected result", longint'(m_tdata[63:0]), 0);
			end else begin
				warp_res_t w;
				w = pending_warps.pop_front();
				if (m_tdata[31:0] !== w.wx) report("warped_x", m_tdata[31:0], w.wx);
				if (m_tdata[63:32] !== w.wy) report("warped_y", m_tdata[63:32], w.wy);
				if (m_tdata[64] !== w.ov) report("overflow", m_tdata[64], w.ov);
				if (w.ov) n_ovf++;
			end
			n_results++;
		end
	end

	// Result side back-pressure, with one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			int gap;
			if (stall_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				stall_req = 1'b0;
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		table_row_t  dir [$];
		logic [31:0] phase_cfg [NUM_PHASES][6];
		warp_res_t   none;
		logic [31:0] x, y;
		int unsigned idx;

		none      = '{default: '0};
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= REQ_LOAD;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ORIGIN_X;
		cfg_data  <= '0;
		errors = 0;
		stall_req = 1'b0;
		org_x = 0;
		org_y = 0;
		scl_x = 65536;
		scl_y = 65536;
		n_cols = 1;
		n_rows = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every lattice entry so that no warp reads an unwritten one.
		for (int i = 0; i < LAT_DEPTH; i++)
			send_item(REQ_LOAD, i, $urandom, $urandom, 1'b0, none);

		// Reset grid: one cell, unit scale, origin zero.
		dir = '{
			'{REQ_LOAD, 0, 32'h00010000, 32'h00020000, 0, 0, 0, 0},
			'{REQ_LOAD, 1, 32'h00030000, 32'h00000000, 0, 0, 0, 0},
			'{REQ_LOAD, 2, 32'h00000000, 32'h00040000, 0, 0, 0, 0},
			'{REQ_LOAD, 3, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0},
			'{REQ_XFORM, 0, 32'h00000000, 32'h00000000, 1, 32'h00010000, 32'h00020000, 0},
			'{REQ_XFORM, 0, 32'h00010000, 32'h00010000, 1, 32'h7FFFFFFF, 32'h80000000, 0},
			'{REQ_XFORM, 0, 32'h00000000, 32'h00010000, 1, 32'h00000000, 32'h00040000, 0},
			'{REQ_XFORM, 0, 32'h00008000, 32'h00008000, 0, 0, 0, 0},
			'{REQ_XFORM, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0},
			'{REQ_XFORM, 0, 32'h80000000, 32'h80000000, 0, 0, 0, 0},
			'{REQ_XFORM, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0},
			'{REQ_XFORM, 0, 32'hFFFF0000, 32'h00030000, 0, 0, 0, 0},
			// Loads past the store are dropped; the last store entry is kept.
			'{REQ_LOAD, 288, 32'h12345678, 32'h9ABCDEF0, 0, 0, 0, 0},
			'{REQ_LOAD, 289, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0},
			'{REQ_LOAD, 511, 32'h00000000, 32'h00000000, 0, 0, 0, 0},
			'{REQ_LOAD, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0},
			'{REQ_XFORM, 0, 32'h00000000, 32'h00000000, 1, 32'h80000000, 32'h7FFFFFFF, 0},
			'{REQ_XFORM, 0, 32'h00018000, 32'hFFFF8000, 0, 0, 0, 0}
		};
		foreach (dir[i]) begin
			send_item(dir[i].req, dir[i].idx, dir[i].x, dir[i].y, dir[i].typed,
				'{dir[i].ex, dir[i].ey, dir[i].eov});
			input_gap(pick_gap());
		end

		// origin_x, origin_y, scale_x, scale_y, columns, rows per phase.
		phase_cfg[0] = '{32'h00000000, 32'h00000000, 32'h00010000, 32'h00010000, 16, 16};
		phase_cfg[1] = '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 16};
		phase_cfg[2] = '{32'h7FFFFFFF, 32'hFFF00000, 32'h00000000, 32'h00001000, 31, 0};
		phase_cfg[3] = '{32'h00123456, 32'hFFEDCBA9, 32'h00004000, 32'h00030000, 7, 5};
		phase_cfg[4] = '{$urandom, $urandom, $urandom_range(0, 32'h7FFFFFFF),
			$urandom_range(1, 32'h00100000), $urandom_range(0, 31), $urandom_range(0, 31)};

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			for (int r = 0; r < 6; r++)
				write_reg(CFG_IDX_W'(r), phase_cfg[p][r]);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// The result side holds off while items keep coming.
				if (p == 0 && k == 100) stall_req = 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, LAT_DEPTH - 1)
						: $urandom_range(0, 511);
					send_item(REQ_LOAD, idx, $urandom, $urandom, 1'b0, none);
				end else begin
					if ($urandom_range(0, 4) < 3) begin
						x = grid_coord(org_x, scl_x, n_cols);
						y = grid_coord(org_y, scl_y, n_rows);
					end else begin
						x = $urandom;
						y = $urandom;
					end
					send_item(REQ_XFORM, $urandom_range(0, 511), x, y, 1'b0, none);
				end
				if (k % 60 > 40) input_gap(pick_gap());
			end
		end
		wait_idle();

		foreach (pending_warps[i])
			report("result never arrived", 0, longint'(pending_warps[i].wx));
		$display("Ran %0d items (%0d loads dropped) over %0d grid settings.", n_items,
			n_ignored, NUM_PHASES + 1);
		$display("Checked %0d warped points, %0d with overflow; %0d errors.", n_results,
			n_ovf, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
